[rtl/u8u16_pkg.sv]
package u8u16_pkg;

    // Byte values used by mark detection and UTF-8 decoding
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_EF   = 8'hEF;
    localparam logic [7:0] BYTE_BB   = 8'hBB;
    localparam logic [7:0] BYTE_BF   = 8'hBF;
    localparam logic [7:0] BYTE_FE   = 8'hFE;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] LEAD_TWO  = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF0;

    // Result candidates per input beat: up to three decoded characters plus the end marker
    localparam int CAND_SLOTS  = 4;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        ENC_UTF8    = 2'd0,
        ENC_UTF16BE = 2'd1,
        ENC_UTF16LE = 2'd2
    } enc_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ONE    = 2'd1,
        PH_EFBB   = 2'd2,
        PH_DECODE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic [1:0]  encoding;
        logic        end_marker;
    } out_beat_t;

    typedef struct packed {
        logic [CAND_SLOTS-1:0]            valid;
        out_beat_t [CAND_SLOTS-1:0]       beat;
    } push_t;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] lead;
        logic [7:0] mid;
    } partial_t;

    typedef struct packed {
        partial_t    part;
        logic        emit;
        logic [15:0] cp;
    } feed_t;

    // One byte into the character decoder
    function automatic feed_t feed(partial_t p, enc_t enc, logic [7:0] b);
        feed_t r;
        r.part = p;
        r.emit = 1'b0;
        r.cp   = '0;
        if (enc != ENC_UTF8)
        begin
            if (p.count == 2'd0)
            begin
                r.part.lead  = b;
                r.part.count = 2'd1;
            end
            else
            begin
                r.emit       = 1'b1;
                r.cp         = (enc == ENC_UTF16BE) ? {p.lead, b} : {b, p.lead};
                r.part.count = 2'd0;
            end
        end
        else
        begin
            case (p.count)
                2'd1:
                begin
                    if (p.lead < LEAD_THREE)
                    begin
                        r.emit       = 1'b1;
                        r.cp         = {5'b0, p.lead[4:0], b[5:0]};
                        r.part.count = 2'd0;
                    end
                    else
                    begin
                        r.part.mid   = b;
                        r.part.count = 2'd2;
                    end
                end
                2'd2:
                begin
                    r.emit       = 1'b1;
                    r.cp         = {p.lead[3:0], p.mid[5:0], b[5:0]};
                    r.part.count = 2'd0;
                end
                default:
                begin
                    if (b >= LEAD_TWO && b < LEAD_LIMIT)
                    begin
                        r.part.lead  = b;
                        r.part.count = 2'd1;
                    end
                    else
                    begin
                        r.emit       = 1'b1;
                        r.cp         = {8'b0, b};
                        r.part.count = 2'd0;
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/u8u16_decode.sv]
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  u8u16_pkg::in_beat_t beat,
    output u8u16_pkg::push_t    push
);

    u8u16_pkg::phase_t phase_reg, phase_next;
    u8u16_pkg::enc_t   enc_reg, enc_next, enc_use;
    logic [1:0]        part_count_reg, part_count_next;
    logic [7:0]        part_lead_reg, part_lead_next;
    logic [7:0]        part_mid_reg, part_mid_next;
    logic [7:0]        held0_reg, held0_next;
    logic [7:0]        held1_reg, held1_next;

    logic [7:0] b;
    logic       endf;
    logic       bom_be, bom_le, efbb_pair;
    logic       a_en, b_en, c_en;
    logic [7:0] a_byte, b_byte, c_byte;
    u8u16_pkg::partial_t p0, p1, p2, p3;
    u8u16_pkg::feed_t    fa, fb, fc;

    assign b    = beat.data_byte;
    assign endf = beat.stream_end;

    assign bom_be    = (held0_reg == u8u16_pkg::BYTE_FE) && (b == u8u16_pkg::BYTE_FF);
    assign bom_le    = (held0_reg == u8u16_pkg::BYTE_FF) && (b == u8u16_pkg::BYTE_FE);
    assign efbb_pair = (held0_reg == u8u16_pkg::BYTE_EF) && (b == u8u16_pkg::BYTE_BB);

    // Next detection phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                u8u16_pkg::PH_IDLE:
                    phase_next = endf ? u8u16_pkg::PH_DECODE : u8u16_pkg::PH_ONE;
                u8u16_pkg::PH_ONE:
                begin
                    if (bom_be || bom_le)
                        phase_next = u8u16_pkg::PH_DECODE;
                    else if (efbb_pair && !endf)
                        phase_next = u8u16_pkg::PH_EFBB;
                    else
                        phase_next = u8u16_pkg::PH_DECODE;
                end
                default:
                    phase_next = u8u16_pkg::PH_DECODE;
            endcase
            // close the document: start over
            if (endf)
                phase_next = u8u16_pkg::PH_IDLE;
        end
    end

    // Pick encoding and the bytes to replay into the decoder
    always_comb
    begin
        enc_use    = enc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        a_en   = 1'b0;
        b_en   = 1'b0;
        c_en   = 1'b0;
        a_byte = b;
        b_byte = b;
        c_byte = b;
        case (phase_reg)
            u8u16_pkg::PH_IDLE:
            begin
                if (endf)
                begin
                    enc_use = u8u16_pkg::ENC_UTF8;
                    a_en    = 1'b1;
                end
                else
                begin
                    held0_next = b;
                end
            end
            u8u16_pkg::PH_ONE:
            begin
                if (bom_be)
                    enc_use = u8u16_pkg::ENC_UTF16BE;
                else if (bom_le)
                    enc_use = u8u16_pkg::ENC_UTF16LE;
                else if (efbb_pair && !endf)
                    held1_next = b;
                else
                begin
                    if (held0_reg == u8u16_pkg::BYTE_ZERO && b != u8u16_pkg::BYTE_ZERO)
                        enc_use = u8u16_pkg::ENC_UTF16BE;
                    else if (held0_reg != u8u16_pkg::BYTE_ZERO && b == u8u16_pkg::BYTE_ZERO)
                        enc_use = u8u16_pkg::ENC_UTF16LE;
                    else
                        enc_use = u8u16_pkg::ENC_UTF8;
                    a_en   = 1'b1;
                    a_byte = held0_reg;
                    b_en   = 1'b1;
                end
            end
            u8u16_pkg::PH_EFBB:
            begin
                enc_use = u8u16_pkg::ENC_UTF8;
                // no mark after EF BB: replay all three bytes
                if (b != u8u16_pkg::BYTE_BF)
                begin
                    a_en   = 1'b1;
                    a_byte = held0_reg;
                    b_en   = 1'b1;
                    b_byte = held1_reg;
                    c_en   = 1'b1;
                end
            end
            default:
                a_en = 1'b1;
        endcase
    end

    // Run up to three bytes through the decoder
    always_comb
    begin
        p0.count = part_count_reg;
        p0.lead  = part_lead_reg;
        p0.mid   = part_mid_reg;
        fa = u8u16_pkg::feed(p0, enc_use, a_byte);
        p1 = a_en ? fa.part : p0;
        fb = u8u16_pkg::feed(p1, enc_use, b_byte);
        p2 = b_en ? fb.part : p1;
        fc = u8u16_pkg::feed(p2, enc_use, c_byte);
        p3 = c_en ? fc.part : p2;
    end

    // Hold state unless a beat is taken; end of stream clears it
    always_comb
    begin
        enc_next        = enc_reg;
        part_count_next = part_count_reg;
        part_lead_next  = part_lead_reg;
        part_mid_next   = part_mid_reg;
        if (take)
        begin
            enc_next        = endf ? u8u16_pkg::ENC_UTF8 : enc_use;
            part_count_next = endf ? 2'd0 : p3.count;
            part_lead_next  = p3.lead;
            part_mid_next   = p3.mid;
        end
    end

    // Result candidates in stream order
    always_comb
    begin
        push.valid[0] = take && a_en && fa.emit;
        push.valid[1] = take && b_en && fb.emit;
        push.valid[2] = take && c_en && fc.emit;
        push.valid[3] = take && endf;
        push.beat[0].code_point = fa.cp;
        push.beat[1].code_point = fb.cp;
        push.beat[2].code_point = fc.cp;
        push.beat[3].code_point = '0;
        for (int i = 0; i < u8u16_pkg::CAND_SLOTS; i++)
        begin
            push.beat[i].encoding   = enc_use;
            push.beat[i].end_marker = (i == u8u16_pkg::CAND_SLOTS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= u8u16_pkg::PH_IDLE;
            enc_reg        <= u8u16_pkg::ENC_UTF8;
            part_count_reg <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            enc_reg        <= enc_next;
            part_count_reg <= part_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_lead_reg <= part_lead_next;
        part_mid_reg  <= part_mid_next;
        if (take)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

[rtl/u8u16_queue.sv]
module u8u16_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8u16_pkg::push_t     push,
    output logic                 room,
    output logic                 valid,
    input  logic                 stall,
    output u8u16_pkg::out_beat_t beat
);

    localparam int DEPTH = u8u16_pkg::MAX_RESULTS + 1;
    localparam int AW    = $clog2(DEPTH);

    u8u16_pkg::out_beat_t q_reg [DEPTH];
    u8u16_pkg::out_beat_t q_next [DEPTH];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW:0]   n_push;
    logic [AW-1:0] slot;
    logic          pop;

    assign valid = (cnt_reg != '0);
    assign beat  = q_reg[rd_ptr_reg];
    assign pop   = valid && !stall;
    // room for a worst-case beat that yields the most results
    assign room  = (cnt_reg <= (AW+1)'(DEPTH - u8u16_pkg::MAX_RESULTS));

    // Pack the valid candidates in order behind the write pointer
    always_comb
    begin
        n_push = '0;
        slot   = '0;
        for (int i = 0; i < DEPTH; i++)
            q_next[i] = q_reg[i];
        for (int i = 0; i < u8u16_pkg::CAND_SLOTS; i++)
        begin
            if (push.valid[i])
            begin
                slot         = wr_ptr_reg + n_push[AW-1:0];
                q_next[slot] = push.beat[i];
                n_push       = n_push + (AW+1)'(1);
            end
        end
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(AW-1){1'b0}}, pop};
        cnt_next    = cnt_reg + n_push - {{AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule

[rtl/utf8_utf16_byte_decoder.sv]
// Latency: a result beat is offered the cycle after the byte that completes it is taken,
// when no older beat waits in the queue.
// Throughput: one byte per cycle while the queue has room; one result beat per cycle leaves
// through the result queue while char_stall is low. Input is held off whenever the queue holds
// more than one beat, so it has room for the three beats a byte may yield (mark replay, end of stream).
// Reset: asynchronous, active low; clears detection, encoding, partial count and queue.
module utf8_utf16_byte_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  u8u16_pkg::in_beat_t  byte_beat,
    output logic                 char_valid,
    input  logic                 char_stall,
    output u8u16_pkg::out_beat_t char_beat
);

    logic             take;
    logic             room;
    u8u16_pkg::push_t push;

    // Take a byte whenever the queue has room for its results
    assign byte_stall = !room;
    assign take       = byte_valid && room;

    u8u16_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (byte_beat),
        .push  (push)
    );

    u8u16_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (char_valid),
        .stall (char_stall),
        .beat  (char_beat)
    );

endmodule

[rtl/u8u16_checker.sv]
module u8u16_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 byte_valid,
    input logic                 byte_stall,
    input u8u16_pkg::in_beat_t  byte_beat,
    input logic                 char_valid,
    input logic                 char_stall,
    input u8u16_pkg::out_beat_t char_beat
);

    // A result beat appears only after a byte was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(char_valid) |-> $past(byte_valid && !byte_stall))
        else $error("result beat without a taken byte");

    // An empty output side never holds off input
    assert property (@(posedge clk) disable iff (!rst_n)
        !char_valid |-> !byte_stall)
        else $error("input stalled while no result is pending");

    // End marker carries no character and the encoding is a known one
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_beat.encoding <= u8u16_pkg::ENC_UTF16LE) &&
                       (!char_beat.end_marker || char_beat.code_point == 16'd0))
        else $error("bad result beat");

    // Stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid)
        else $error("result beat dropped while stalled");

    // Stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> $stable(char_beat))
        else $error("result beat changed while stalled");

endmodule

bind utf8_utf16_byte_decoder u8u16_checker u_checker (.*);
